/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SPP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spp assertion failed");

// checked at every edge, reset included
`define SPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spp assertion failed");

`endif

/* hw/rtl/spp_pkg.sv */
// spectral peak picker package: sizes, config codes, shared types
// no dependencies
package spp_pkg;

  localparam int BINS          = 512;
  localparam int HALF_TIME     = 12;
  localparam int HALF_FREQ_MAX = 51;
  localparam int TIME_SPAN     = 2 * HALF_TIME + 1;
  localparam int MAX_PEAKS     = 52;
  localparam int BIN_W         = $clog2(BINS);
  localparam int SLOT_W        = $clog2(TIME_SPAN);
  localparam int HIST_DEPTH    = TIME_SPAN * BINS;
  localparam int ADDR_W        = $clog2(HIST_DEPTH);
  localparam int PEAK_W        = $clog2(MAX_PEAKS + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SQRT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAGNITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW   = 2'd3;

  typedef struct packed {
    logic        sqrt_mode;
    logic [31:0] min_magnitude;
    logic [8:0]  min_bin;
    logic [5:0]  half_freq_window;
  } cfg_t;

  typedef struct packed {
    logic [31:0] power;
    logic [22:0] frame_number;
    logic        frame_end;
  } entry_t;

  function automatic logic [ADDR_W-1:0] hist_addr(logic [SLOT_W-1:0] slot,
                                                  logic [BIN_W-1:0] bin);
    return ADDR_W'(int'(slot) * BINS + int'(bin));
  endfunction

endpackage

/* hw/rtl/spp_if.sv */
// request channel interfaces: bin input, peak output, config writes
// depends on spp_pkg
interface spp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_part;
  logic signed [15:0] imag_part;
  logic [22:0]        frame_number;
  logic               frame_end;
  modport source(output valid, real_part, imag_part, frame_number, frame_end, input ready);
  modport sink(input valid, real_part, imag_part, frame_number, frame_end, output ready);
endinterface

interface spp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] peak_time;
  logic [8:0]         peak_bin;
  logic [31:0]        peak_magnitude;
  logic               run_last;
  modport source(output valid, peak_time, peak_bin, peak_magnitude, run_last, input ready);
  modport sink(input valid, peak_time, peak_bin, peak_magnitude, run_last, output ready);
endinterface

interface spp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spp_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/spp_ram.sv */
// generic single-write, single-read ram with registered read
// no dependencies
module spp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/spp_front.sv */
// front end: takes bin requests and forms the power re*re + im*im
// depends on spp_pkg, spp_if
module spp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  spp_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output spp_pkg::entry_t entry_o
);
  logic        valid_q;
  logic [31:0] sq_re_q, sq_im_q;
  logic [22:0] frame_q;
  logic        end_q;
  logic        take;

  assign in_i.ready = !valid_q || !full_i;
  assign take       = in_i.valid && in_i.ready;
  assign push_o     = valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sq_re_q <= 32'(in_i.real_part * in_i.real_part);
      sq_im_q <= 32'(in_i.imag_part * in_i.imag_part);
      frame_q <= in_i.frame_number;
      end_q   <= in_i.frame_end;
    end
  end

  always_comb begin
    entry_o.power        = sq_re_q + sq_im_q;
    entry_o.frame_number = frame_q;
    entry_o.frame_end    = end_q;
  end
endmodule

/* hw/rtl/spp_queue.sv */
// short fifo between front end and back end
// depends on spp_pkg
module spp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spp_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output spp_pkg::entry_t entry_o
);
  spp_pkg::entry_t             slots_q [spp_pkg::QUEUE_DEPTH];
  logic [spp_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [spp_pkg::QPTR_W:0]    cnt_q;

  assign full_o  = cnt_q == (spp_pkg::QPTR_W + 1)'(spp_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= entry_i;
  end
endmodule

/* hw/rtl/spp_back.sv */
// back end: root, history writes, frequency max filter, peak search
// depends on spp_pkg, spp_if, spp_ram
module spp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spp_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  spp_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  spp_out_if.source       out_o
);
  localparam int BW = spp_pkg::BIN_W;
  localparam int SW = spp_pkg::SLOT_W;
  localparam logic [BW-1:0] LAST_BIN  = BW'(spp_pkg::BINS - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(spp_pkg::TIME_SPAN - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROOT   = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_FILL   = 4'd3;
  localparam logic [3:0] S_FILT   = 4'd4;
  localparam logic [3:0] S_FDRAIN = 4'd5;
  localparam logic [3:0] S_NEXT   = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_TIME   = 4'd8;
  localparam logic [3:0] S_TWAIT  = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [BW-1:0] pos_q, pos_d, j_q, j_d, k_q, k_d, pj_q;
  logic [SW-1:0] filled_q, filled_d, slot_q, slot_d, center_q, center_d, t_q, t_d;
  logic [31:0] val_q, val_d, root_q, root_d, bit_q, bit_d, mag_q, mag_d;
  logic [31:0] cur_q, cur_d, acc_q;
  logic [22:0] frame_q, frame_d;
  logic        end_q, end_d, first_q, first_d;
  logic        p_valid_q, p_first_q, p_last_q, p_wr_q;
  logic        issue, issue_last, issue_wr;
  logic [spp_pkg::PEAK_W-1:0] n_q, n_d;
  logic        pend_q, pend_d;
  logic [BW-1:0] pend_bin_q, pend_bin_d;
  logic [31:0] pend_mag_q, pend_mag_d;
  logic        out_push, out_last;
  logic        out_free;

  logic        mag_we, fmx_we;
  logic [spp_pkg::ADDR_W-1:0] mag_waddr, mag_raddr, fmx_waddr, fmx_raddr;
  logic [31:0] mag_wdata, mag_rdata, fmx_rdata, pmax;

  logic [5:0]    win;
  logic [BW:0]   jx, jnx, wx, hi_sum, hi_cur, lo_next;
  logic [31:0]   trial;
  logic [SW:0]   center_sum;

  spp_ram #(.WIDTH(32), .DEPTH(spp_pkg::HIST_DEPTH)) u_mag_ram (
    .clk_i(clk_i), .we_i(mag_we), .waddr_i(mag_waddr), .wdata_i(mag_wdata),
    .raddr_i(mag_raddr), .rdata_o(mag_rdata)
  );

  spp_ram #(.WIDTH(32), .DEPTH(spp_pkg::HIST_DEPTH)) u_fmax_ram (
    .clk_i(clk_i), .we_i(fmx_we), .waddr_i(fmx_waddr), .wdata_i(pmax),
    .raddr_i(fmx_raddr), .rdata_o(fmx_rdata)
  );

  assign out_free = !out_o.valid || out_o.ready;

  function automatic logic [31:0] pipe_data();
    return p_wr_q ? mag_rdata : fmx_rdata;
  endfunction

  function automatic logic mag_or_fmx_gt();
    return pipe_data() > acc_q;
  endfunction

  // frequency window bounds, root trial, centre slot sum and running max
  always_comb begin
    win     = (cfg_i.half_freq_window > 6'(spp_pkg::HALF_FREQ_MAX)) ?
              6'(spp_pkg::HALF_FREQ_MAX) : cfg_i.half_freq_window;
    wx      = (BW + 1)'(win);
    jx      = {1'b0, j_q};
    jnx     = jx + 1'b1;
    hi_sum  = jx + wx;
    hi_cur  = (hi_sum > {1'b0, LAST_BIN}) ? {1'b0, LAST_BIN} : hi_sum;
    lo_next = (jnx >= wx) ? jnx - wx : '0;
    trial   = root_q + bit_q;
    center_sum = (SW + 1)'(slot_q) + (SW + 1)'(spp_pkg::HALF_TIME + 1);
    pmax    = (p_first_q || mag_or_fmx_gt()) ? pipe_data() : acc_q;
  end

  assign fmx_we    = p_valid_q && p_last_q && p_wr_q;
  assign fmx_waddr = spp_pkg::hist_addr(slot_q, pj_q);
  assign fmx_raddr = spp_pkg::hist_addr((state_q == S_TIME) ? t_q : center_q, j_q);
  assign mag_raddr = spp_pkg::hist_addr((state_q == S_FILT) ? slot_q : center_q,
                                        (state_q == S_FILT) ? k_q : j_q);
  assign mag_we    = (state_q == S_WRITE) || (state_q == S_FILL);
  assign mag_waddr = spp_pkg::hist_addr(slot_q, (state_q == S_WRITE) ? pos_q : k_q);
  assign mag_wdata = (state_q == S_WRITE) ? mag_q : '0;

  always_comb begin
    state_d = state_q;  pos_d = pos_q;  j_d = j_q;  k_d = k_q;
    filled_d = filled_q;  slot_d = slot_q;  center_d = center_q;  t_d = t_q;
    val_d = val_q;  root_d = root_q;  bit_d = bit_q;  mag_d = mag_q;
    cur_d = cur_q;  frame_d = frame_q;  end_d = end_q;  first_d = first_q;
    n_d = n_q;  pend_d = pend_q;  pend_bin_d = pend_bin_q;  pend_mag_d = pend_mag_q;
    q_pop_o = 1'b0;  issue = 1'b0;  issue_last = 1'b0;  issue_wr = 1'b0;
    out_push = 1'b0;  out_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          frame_d = q_entry_i.frame_number;
          end_d   = q_entry_i.frame_end;
          val_d   = q_entry_i.power;
          mag_d   = q_entry_i.power;
          root_d  = '0;
          bit_d   = 32'h4000_0000;
          state_d = cfg_i.sqrt_mode ? S_ROOT : S_WRITE;
        end
      end
      S_ROOT: begin
        if (val_q >= trial) begin
          val_d  = val_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 32'd1) begin
          mag_d   = root_d;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!end_q && pos_q != LAST_BIN) begin
          pos_d   = pos_q + 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d = '0;
          if (pos_q == LAST_BIN) begin
            j_d = '0;  k_d = '0;  first_d = 1'b1;
            state_d = S_FILT;
          end else begin
            k_d     = pos_q + 1'b1;
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (k_q == LAST_BIN) begin
          j_d = '0;  k_d = '0;  first_d = 1'b1;
          state_d = S_FILT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FILT: begin
        issue      = 1'b1;
        issue_wr   = 1'b1;
        issue_last = {1'b0, k_q} == hi_cur;
        if (issue_last) begin
          if (j_q == LAST_BIN) begin
            state_d = S_FDRAIN;
          end else begin
            j_d     = j_q + 1'b1;
            k_d     = BW'(lo_next);
            first_d = 1'b1;
          end
        end else begin
          k_d     = k_q + 1'b1;
          first_d = 1'b0;
        end
      end
      S_FDRAIN: begin
        if (filled_q != LAST_SLOT) begin
          filled_d = filled_q + 1'b1;
          slot_d   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
          state_d  = S_IDLE;
        end else begin
          center_d = (center_sum >= (SW + 1)'(spp_pkg::TIME_SPAN)) ?
                     SW'(center_sum - (SW + 1)'(spp_pkg::TIME_SPAN)) : SW'(center_sum);
          n_d    = '0;
          pend_d = 1'b0;
          if (32'(cfg_i.min_bin) >= 32'(spp_pkg::BINS - 1)) begin
            state_d = S_FIN;
          end else begin
            j_d     = BW'(cfg_i.min_bin);
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (j_q == LAST_BIN || n_q == spp_pkg::PEAK_W'(spp_pkg::MAX_PEAKS)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (mag_rdata < cfg_i.min_magnitude || mag_rdata != fmx_rdata) begin
          j_d     = j_q + 1'b1;
          state_d = S_NEXT;
        end else begin
          cur_d   = mag_rdata;
          t_d     = '0;
          state_d = S_TIME;
        end
      end
      S_TIME: begin
        issue      = 1'b1;
        issue_last = t_q == LAST_SLOT;
        first_d    = t_q == '0;
        t_d        = t_q + 1'b1;
        if (issue_last) state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (pmax == cur_q) begin
          state_d = S_PUSH;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_NEXT;
        end
      end
      S_PUSH: begin
        if (!pend_q || out_free) begin
          out_push   = pend_q;
          pend_d     = 1'b1;
          pend_bin_d = j_q;
          pend_mag_d = cur_q;
          n_d        = n_q + 1'b1;
          j_d        = j_q + 1'b1;
          state_d    = S_NEXT;
        end
      end
      S_FIN: begin
        if (!pend_q || out_free) begin
          out_push = pend_q;
          out_last = 1'b1;
          pend_d   = 1'b0;
          slot_d   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // first flag for the time scan comes straight from t
  logic issue_first;
  assign issue_first = (state_q == S_TIME) ? (t_q == '0) : first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      filled_q  <= '0;
      slot_q    <= '0;
      pend_q    <= 1'b0;
      p_valid_q <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      filled_q  <= filled_d;
      slot_q    <= slot_d;
      pend_q    <= pend_d;
      p_valid_q <= issue;
      if (out_push) out_o.valid <= 1'b1;
      else if (out_o.ready) out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;  k_q <= k_d;  center_q <= center_d;  t_q <= t_d;
    val_q <= val_d;  root_q <= root_d;  bit_q <= bit_d;  mag_q <= mag_d;
    cur_q <= cur_d;  frame_q <= frame_d;  end_q <= end_d;  first_q <= first_d;
    n_q <= n_d;  pend_bin_q <= pend_bin_d;  pend_mag_q <= pend_mag_d;
    p_first_q <= issue_first;
    p_last_q  <= issue_last;
    p_wr_q    <= issue_wr;
    pj_q      <= j_q;
    if (p_valid_q) acc_q <= pmax;
    if (out_push) begin
      out_o.peak_time      <= 24'({1'b0, frame_q} - 24'(spp_pkg::HALF_TIME));
      out_o.peak_bin       <= 9'(pend_bin_q);
      out_o.peak_magnitude <= pend_mag_q;
      out_o.run_last       <= out_last;
    end
  end
endmodule

/* hw/rtl/spectral_peak_picker.sv */
// Spectral peak picker. Bins arrive on in_i as one request each; a front end forms the power
// (two registered multiplies) and queues it, a back end takes one queued bin at a time. A bin
// takes a pop, 16 root steps one per cycle and a write in root mode, and a pop and a write in
// power mode. The last bin of a frame adds the zero fill of missing bins, then the frequency
// max filter, which reads the magnitude memory once per window tap. Once 25 frames are held,
// the peak search adds a next and a check state per bin, a scan of all time slots of the max
// memory per candidate and a push state per peak, limited by the single read port of the max
// memory. Peaks leave on out_o in ascending bin order, run_last on the last one of a frame.
// No clearing pass.
// depends on spp_pkg, spp_if, spp_front, spp_queue, spp_back
module spectral_peak_picker (
  input  logic      clk_i,
  input  logic      rst_ni,
  spp_in_if.sink    in_i,
  spp_out_if.source out_o,
  spp_cfg_if.sink   cfg_i
);
  spp_pkg::cfg_t   cfg_q;
  spp_pkg::entry_t front_entry, queue_entry;
  logic            push, full, pop, q_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sqrt_mode        <= 1'b1;
      cfg_q.min_magnitude    <= '0;
      cfg_q.min_bin          <= '0;
      cfg_q.half_freq_window <= 6'(spp_pkg::HALF_FREQ_MAX);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        spp_pkg::CFG_SQRT_MODE:     cfg_q.sqrt_mode        <= cfg_i.data[0];
        spp_pkg::CFG_MIN_MAGNITUDE: cfg_q.min_magnitude    <= cfg_i.data;
        spp_pkg::CFG_MIN_BIN:       cfg_q.min_bin          <= cfg_i.data[8:0];
        spp_pkg::CFG_HALF_WINDOW:   cfg_q.half_freq_window <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  spp_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i),
    .full_i(full), .push_o(push), .entry_o(front_entry)
  );

  spp_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .entry_i(front_entry),
    .full_o(full), .pop_i(pop), .valid_o(q_valid), .entry_o(queue_entry)
  );

  spp_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q), .q_valid_i(q_valid),
    .q_entry_i(queue_entry), .q_pop_o(pop), .out_o(out_o)
  );
endmodule

/* hw/rtl/spp_checker.sv */
// port-level checks on the peak picker, bound to the top level
// depends on assert_macros.svh, spp_pkg
`include "assert_macros.svh"

module spp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] peak_time_i,
  input logic [8:0]  peak_bin_i,
  input logic [31:0] peak_magnitude_i,
  input logic        run_last_i,
  input logic        cfg_ready_i
);
  // stalled peak holds
  `SPP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(peak_time_i) && $stable(peak_bin_i) && $stable(peak_magnitude_i) && $stable(run_last_i))
  // last bin of a frame is never examined
  `SPP_ASSERT(a_bin_range, clk_i, rst_ni, out_valid_i |-> 32'(peak_bin_i) < spp_pkg::BINS - 1)
  // config port never stalls
  `SPP_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_i)
  // nothing shown right after a reset edge
  `SPP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i)
endmodule

bind spectral_peak_picker spp_checker u_spp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .peak_time_i(out_o.peak_time), .peak_bin_i(out_o.peak_bin),
  .peak_magnitude_i(out_o.peak_magnitude), .run_last_i(out_o.run_last),
  .cfg_ready_i(cfg_i.ready)
);
